[hdl/psn_pkg.sv]
`timescale 1ns / 1ps
// psn_pkg: shared types, codes and helper functions for the surface normal unit.
// No dependencies; imported by psn_front, psn_norm, the top, checker and bench.
package psn_pkg;

  localparam int MagW = 62;   // direction magnitude width
  localparam int AW   = 30;   // scaled magnitude width, top bit weight 2^29
  localparam int LenW = 31;   // vector length width
  localparam int QW   = 15;   // quotient width, up to 16384

  localparam logic [2:0] KIND_FLAT    = 3'd0;
  localparam logic [2:0] KIND_RAMP    = 3'd1;
  localparam logic [2:0] KIND_DISK    = 3'd2;
  localparam logic [2:0] KIND_BALL    = 3'd3;
  localparam logic [2:0] KIND_CONE    = 3'd4;
  localparam logic [2:0] KIND_PYRAMID = 3'd5;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_KIND  = 2'd1;
  localparam logic [1:0] ST_PYR_RANGE = 2'd2;
  localparam logic [1:0] ST_ZERO_LEN  = 2'd3;

  localparam logic [15:0] ONE_Q14       = 16'h4000;
  localparam logic [15:0] MINUS_ONE_Q14 = 16'hC000;
  localparam logic [15:0] RAMP_MARGIN_RST = 16'd6554;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] xl, xh, yl, yh, zl, zh, hx, hy, hz;
  } psn_in_t;

  typedef struct packed {
    logic        fixed;   // result known, no normalisation
    logic [1:0]  status;
    logic [15:0] fx, fy, fz;
    logic [2:0]  neg;     // component signs, x in bit 0
  } psn_ctl_t;

  typedef struct packed {
    psn_ctl_t              ctl;
    logic [2:0][MagW-1:0]  mag;
  } psn_vec_t;

  typedef struct packed {
    logic [15:0] nx, ny, nz;
    logic [1:0]  status;
  } psn_res_t;

  // position of the leading one (0 when m is zero)
  function automatic logic [5:0] msb_pos(input logic [MagW-1:0] m);
    logic [5:0] p;
    p = '0;
    for (int i = 0; i < MagW; i++) begin
      if (m[i]) p = 6'(i);
    end
    return p;
  endfunction

  // bring a magnitude whose reference leading one sits at p to weight 2^29
  function automatic logic [AW-1:0] scale_mag(input logic [MagW-1:0] m,
                                              input logic [5:0] p);
    logic [MagW-1:0] t;
    if (p >= 6'(AW - 1)) t = m >> (p - 6'(AW - 1));
    else t = m << (6'(AW - 1) - p);
    return t[AW-1:0];
  endfunction

endpackage

[hdl/psn_front.sv]
`timescale 1ns / 1ps
// psn_front: per-kind geometry, nine stages from raw item to direction vector.
// Depends on psn_pkg.
module psn_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              in_valid_i,
  input  psn_pkg::psn_in_t  in_i,
  input  logic [15:0]       margin_i,
  output logic              out_valid_o,
  output psn_pkg::psn_vec_t out_o
);
  import psn_pkg::*;

  typedef struct packed {
    logic [2:0]  kind;
    logic [33:0] ux, uy, uzb, uzc;
    logic [32:0] dx, dy, dz;
    logic        zb, za, ze;
    logic [31:0] xl, xh, hx;
  } st2_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [49:0] prod;
    logic [33:0] dsum;
    logic [34:0] h4;
    logic [32:0] dz;
    logic [33:0] mux, muy, muzb, muzc;
    logic        sx, sy, szb, szc;
    logic        zb, za, ze;
    logic [31:0] xl, xh, hx;
  } st3_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [33:0] blo, bhi;
    logic [31:0] hx;
    logic [32:0] dz;
    logic [34:0] h4;
    logic [33:0] dsum;
    logic [33:0] mux, muy, muzb, muzc;
    logic        sx, sy, szb, szc;
    logic        pyr_oor, pyr_xside, ze, cone_triv;
    logic [33:0] hmax;
  } st4_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic        in_band;
    logic [34:0] rz;
    logic [32:0] dz;
    logic [34:0] h4;
    logic [33:0] dsum;
    logic [33:0] mux, muy, muzb, muzc;
    logic        sx, sy, szb, szc;
    logic        pyr_oor, pyr_xside, ze, cone_triv;
    logic [5:0]  p1, p2;
  } st5_t;

  typedef struct packed {
    psn_vec_t       vec;
    logic           cone;
    logic [AW-1:0]  ax, ay, bz;
    logic [6:0]     dexp;
  } st6_t;

  typedef struct packed {
    psn_vec_t    vec;
    logic        cone;
    logic [59:0] px, py, qx, qy;
    logic [6:0]  dexp;
  } st7_t;

  typedef struct packed {
    psn_vec_t    vec;
    logic        cone;
    logic [59:0] px, py;
    logic [60:0] h;
    logic [6:0]  dexp;
  } st8_t;

  function automatic psn_vec_t mk_fixed(input logic [15:0] fz, input logic [1:0] st);
    psn_vec_t v;
    v            = '0;
    v.ctl.fixed  = 1'b1;
    v.ctl.status = st;
    v.ctl.fz     = fz;
    return v;
  endfunction

  function automatic logic [33:0] abs34(input logic [33:0] v);
    return v[33] ? 34'(-v) : v;
  endfunction

  logic [8:0] v_q;
  psn_in_t    s1_q;
  st2_t       s2_q, s2_d;
  st3_t       s3_q, s3_d;
  st4_t       s4_q, s4_d;
  st5_t       s5_q, s5_d;
  st6_t       s6_q, s6_d;
  st7_t       s7_q, s7_d;
  st8_t       s8_q, s8_d;
  psn_vec_t   s9_q, s9_d;

  logic [32:0] dzh;
  logic [32:0] off;
  logic [33:0] hx_ext;
  logic [32:0] dz_mag;
  logic [34:0] rz_mag, h4_mag;
  logic [60:0] h_al;
  logic [59:0] px_al, py_al;
  logic [6:0]  ndexp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[7:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_q <= in_i;
      s2_q <= s2_d;
      s3_q <= s3_d;
      s4_q <= s4_d;
      s5_q <= s5_d;
      s6_q <= s6_d;
      s7_q <= s7_d;
      s8_q <= s8_d;
      s9_q <= s9_d;
    end
  end

  // differences and centred offsets
  always_comb begin
    s2_d      = '0;
    s2_d.kind = s1_q.kind;
    s2_d.ux   = {s1_q.hx[31], s1_q.hx, 1'b0}
              - ({{2{s1_q.xl[31]}}, s1_q.xl} + {{2{s1_q.xh[31]}}, s1_q.xh});
    s2_d.uy   = {s1_q.hy[31], s1_q.hy, 1'b0}
              - ({{2{s1_q.yl[31]}}, s1_q.yl} + {{2{s1_q.yh[31]}}, s1_q.yh});
    s2_d.uzb  = {s1_q.hz[31], s1_q.hz, 1'b0}
              - ({{2{s1_q.zl[31]}}, s1_q.zl} + {{2{s1_q.zh[31]}}, s1_q.zh});
    dzh       = {s1_q.hz[31], s1_q.hz} - {s1_q.zh[31], s1_q.zh};
    s2_d.uzc  = {dzh, 1'b0};
    s2_d.dx   = {s1_q.xh[31], s1_q.xh} - {s1_q.xl[31], s1_q.xl};
    s2_d.dy   = {s1_q.yh[31], s1_q.yh} - {s1_q.yl[31], s1_q.yl};
    s2_d.dz   = {s1_q.zh[31], s1_q.zh} - {s1_q.zl[31], s1_q.zl};
    s2_d.zb   = $signed(s1_q.hz) < $signed(s1_q.zl);
    s2_d.za   = $signed(s1_q.hz) > $signed(s1_q.zh);
    s2_d.ze   = s1_q.hz == s1_q.zl;
    s2_d.xl   = s1_q.xl;
    s2_d.xh   = s1_q.xh;
    s2_d.hx   = s1_q.hx;
  end

  // ramp margin product, magnitudes
  always_comb begin
    s3_d      = '0;
    s3_d.kind = s2_q.kind;
    s3_d.prod = $signed({1'b0, margin_i}) * $signed(s2_q.dx);
    s3_d.dsum = {s2_q.dx[32], s2_q.dx} + {s2_q.dy[32], s2_q.dy};
    s3_d.h4   = {s2_q.dz, 2'b00};
    s3_d.dz   = s2_q.dz;
    s3_d.mux  = abs34(s2_q.ux);
    s3_d.muy  = abs34(s2_q.uy);
    s3_d.muzb = abs34(s2_q.uzb);
    s3_d.muzc = abs34(s2_q.uzc);
    s3_d.sx   = s2_q.ux[33];
    s3_d.sy   = s2_q.uy[33];
    s3_d.szb  = s2_q.uzb[33];
    s3_d.szc  = s2_q.uzc[33];
    s3_d.zb   = s2_q.zb;
    s3_d.za   = s2_q.za;
    s3_d.ze   = s2_q.ze;
    s3_d.xl   = s2_q.xl;
    s3_d.xh   = s2_q.xh;
    s3_d.hx   = s2_q.hx;
  end

  // band edges, pyramid range, cone reference magnitude
  always_comb begin
    s4_d           = '0;
    off            = s3_q.prod[49:17];  // floor division by 2^17
    s4_d.kind      = s3_q.kind;
    s4_d.blo       = {{2{s3_q.xl[31]}}, s3_q.xl} + {off[32], off};
    s4_d.bhi       = {{2{s3_q.xh[31]}}, s3_q.xh} - {off[32], off};
    s4_d.hx        = s3_q.hx;
    s4_d.dz        = s3_q.dz;
    s4_d.h4        = s3_q.h4;
    s4_d.dsum      = s3_q.dsum;
    s4_d.mux       = s3_q.mux;
    s4_d.muy       = s3_q.muy;
    s4_d.muzb      = s3_q.muzb;
    s4_d.muzc      = s3_q.muzc;
    s4_d.sx        = s3_q.sx;
    s4_d.sy        = s3_q.sy;
    s4_d.szb       = s3_q.szb;
    s4_d.szc       = s3_q.szc;
    s4_d.pyr_oor   = s3_q.zb || s3_q.za || s3_q.dsum[33]
                   || ({s3_q.mux, 1'b0} > {1'b0, s3_q.dsum})
                   || ({s3_q.muy, 1'b0} > {1'b0, s3_q.dsum});
    s4_d.pyr_xside = s3_q.mux > s3_q.muy;
    s4_d.ze        = s3_q.ze;
    s4_d.cone_triv = ((s3_q.mux == '0) && (s3_q.muy == '0)) || (s3_q.muzc == '0);
    s4_d.hmax      = (s3_q.mux > s3_q.muy) ? s3_q.mux : s3_q.muy;
  end

  // band test, ramp slope, cone exponents
  always_comb begin
    s5_d           = '0;
    hx_ext         = {{2{s4_q.hx[31]}}, s4_q.hx};
    s5_d.kind      = s4_q.kind;
    s5_d.in_band   = !(($signed(hx_ext) <= $signed(s4_q.blo))
                    || ($signed(hx_ext) >= $signed(s4_q.bhi)));
    s5_d.rz        = {s4_q.bhi[33], s4_q.bhi} - {s4_q.blo[33], s4_q.blo};
    s5_d.dz        = s4_q.dz;
    s5_d.h4        = s4_q.h4;
    s5_d.dsum      = s4_q.dsum;
    s5_d.mux       = s4_q.mux;
    s5_d.muy       = s4_q.muy;
    s5_d.muzb      = s4_q.muzb;
    s5_d.muzc      = s4_q.muzc;
    s5_d.sx        = s4_q.sx;
    s5_d.sy        = s4_q.sy;
    s5_d.szb       = s4_q.szb;
    s5_d.szc       = s4_q.szc;
    s5_d.pyr_oor   = s4_q.pyr_oor;
    s5_d.pyr_xside = s4_q.pyr_xside;
    s5_d.ze        = s4_q.ze;
    s5_d.cone_triv = s4_q.cone_triv;
    s5_d.p1        = msb_pos(MagW'(s4_q.hmax));
    s5_d.p2        = msb_pos(MagW'(s4_q.muzc));
  end

  // direction vector per kind; cone operands scaled
  always_comb begin
    s6_d      = '0;
    dz_mag    = s5_q.dz[32] ? 33'(-s5_q.dz) : s5_q.dz;
    rz_mag    = s5_q.rz[34] ? 35'(-s5_q.rz) : s5_q.rz;
    h4_mag    = s5_q.h4[34] ? 35'(-s5_q.h4) : s5_q.h4;
    s6_d.ax   = scale_mag(MagW'(s5_q.mux), s5_q.p1);
    s6_d.ay   = scale_mag(MagW'(s5_q.muy), s5_q.p1);
    s6_d.bz   = scale_mag(MagW'(s5_q.muzc), s5_q.p2);
    s6_d.dexp = 7'(s5_q.p2) - 7'(s5_q.p1);
    s6_d.cone = 1'b0;
    unique case (s5_q.kind)
      KIND_FLAT, KIND_DISK: s6_d.vec = mk_fixed(ONE_Q14, ST_OK);
      KIND_RAMP: begin
        if (!s5_q.in_band) begin
          s6_d.vec = mk_fixed(ONE_Q14, ST_OK);
        end else begin
          // x = -(z_hi - z_lo), z = band width
          s6_d.vec.ctl.neg[0] = !s5_q.dz[32] && (s5_q.dz != '0);
          s6_d.vec.ctl.neg[2] = s5_q.rz[34];
          s6_d.vec.mag[0]     = MagW'(dz_mag);
          s6_d.vec.mag[2]     = MagW'(rz_mag);
        end
      end
      KIND_BALL: begin
        s6_d.vec.ctl.neg = {s5_q.szb, s5_q.sy, s5_q.sx};
        s6_d.vec.mag[0]  = MagW'(s5_q.mux);
        s6_d.vec.mag[1]  = MagW'(s5_q.muy);
        s6_d.vec.mag[2]  = MagW'(s5_q.muzb);
      end
      KIND_CONE: begin
        if (s5_q.cone_triv) begin
          s6_d.vec = mk_fixed(ONE_Q14, ST_OK);
        end else begin
          // -uz*u is negative when uz and u share a sign
          s6_d.cone           = 1'b1;
          s6_d.vec.ctl.neg[0] = s5_q.szc == s5_q.sx;
          s6_d.vec.ctl.neg[1] = s5_q.szc == s5_q.sy;
        end
      end
      KIND_PYRAMID: begin
        if (s5_q.pyr_oor) begin
          s6_d.vec = mk_fixed('0, ST_PYR_RANGE);
        end else if (s5_q.ze) begin
          s6_d.vec = mk_fixed(MINUS_ONE_Q14, ST_OK);
        end else if (s5_q.pyr_xside) begin
          s6_d.vec.ctl.neg[0] = s5_q.sx ^ s5_q.h4[34];
          s6_d.vec.mag[0]     = MagW'(h4_mag);
          s6_d.vec.mag[2]     = MagW'(s5_q.dsum);
        end else begin
          s6_d.vec.ctl.neg[1] = s5_q.sy ^ s5_q.h4[34];
          s6_d.vec.mag[1]     = MagW'(h4_mag);
          s6_d.vec.mag[2]     = MagW'(s5_q.dsum);
        end
      end
      default: s6_d.vec = mk_fixed('0, ST_BAD_KIND);
    endcase
  end

  // cone products
  always_comb begin
    s7_d.vec  = s6_q.vec;
    s7_d.cone = s6_q.cone;
    s7_d.dexp = s6_q.dexp;
    s7_d.px   = s6_q.bz * s6_q.ax;
    s7_d.py   = s6_q.bz * s6_q.ay;
    s7_d.qx   = s6_q.ax * s6_q.ax;
    s7_d.qy   = s6_q.ay * s6_q.ay;
  end

  always_comb begin
    s8_d.vec  = s7_q.vec;
    s8_d.cone = s7_q.cone;
    s8_d.dexp = s7_q.dexp;
    s8_d.px   = s7_q.px;
    s8_d.py   = s7_q.py;
    s8_d.h    = {1'b0, s7_q.qx} + {1'b0, s7_q.qy};
  end

  // align the cone terms to the larger exponent
  always_comb begin
    ndexp = 7'(-s8_q.dexp);
    h_al  = s8_q.h;
    px_al = s8_q.px;
    py_al = s8_q.py;
    if (!s8_q.dexp[6]) begin
      h_al = s8_q.h >> s8_q.dexp[5:0];
    end else begin
      px_al = s8_q.px >> ndexp[5:0];
      py_al = s8_q.py >> ndexp[5:0];
    end
    s9_d = s8_q.vec;
    if (s8_q.cone) begin
      s9_d.mag[0] = MagW'(px_al);
      s9_d.mag[1] = MagW'(py_al);
      s9_d.mag[2] = MagW'(h_al);
    end
  end

  assign out_valid_o = v_q[8];
  assign out_o       = s9_q;

endmodule

[hdl/psn_norm.sv]
`timescale 1ns / 1ps
// psn_norm: vector normalisation - scaling, pipelined square root and divider.
// Depends on psn_pkg.
module psn_norm (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              in_valid_i,
  input  psn_pkg::psn_vec_t in_i,
  output logic              out_valid_o,
  output psn_pkg::psn_res_t out_o
);
  import psn_pkg::*;

  localparam int SqSteps  = LenW;          // one result bit per stage
  localparam int DivSteps = QW;            // one quotient bit per stage
  localparam int RemW     = AW + 16;
  localparam int SqBase   = 5;
  localparam int DvBase   = SqBase + SqSteps + 1;
  localparam int NStages  = DvBase + DivSteps + 1;

  logic [NStages-1:0] v_q;

  psn_vec_t          n1_vec_q, n2_vec_q, n2_vec_d, n3_vec_q;
  logic [MagW-1:0]   n1_m01_q, n2_mx_q;
  logic [5:0]        n3_p_q;
  psn_ctl_t          n4_ctl_q, n5_ctl_q;
  logic [2:0][AW-1:0] n4_a_q, n5_a_q;
  logic [2:0][2*AW-1:0] n5_sq_q;

  psn_ctl_t           sq_ctl_q [SqSteps+1];
  logic [2:0][AW-1:0] sq_a_q   [SqSteps+1];
  logic [MagW-1:0]    sq_n_q   [SqSteps+1];
  logic [MagW-1:0]    sq_r_q   [SqSteps+1];

  psn_ctl_t             dv_ctl_q [DivSteps+1];
  logic [LenW-1:0]      dv_len_q [DivSteps+1];
  logic [2:0][RemW-1:0] dv_rem_q [DivSteps+1];
  logic [2:0][QW-1:0]   dv_quo_q [DivSteps+1];

  logic [MagW-1:0]    mx;
  logic [LenW-1:0]    len0;
  psn_ctl_t           oc;
  logic [2:0][15:0]   comp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[NStages-2:0], in_valid_i};
    end
  end

  // zero-length check on the largest magnitude
  always_comb begin
    mx       = (n1_m01_q > n1_vec_q.mag[2]) ? n1_m01_q : n1_vec_q.mag[2];
    n2_vec_d = n1_vec_q;
    if (!n1_vec_q.ctl.fixed && (mx == '0)) begin
      n2_vec_d.ctl.fixed  = 1'b1;
      n2_vec_d.ctl.status = ST_ZERO_LEN;
      n2_vec_d.ctl.fx     = '0;
      n2_vec_d.ctl.fy     = '0;
      n2_vec_d.ctl.fz     = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n1_vec_q <= in_i;
      n1_m01_q <= (in_i.mag[0] > in_i.mag[1]) ? in_i.mag[0] : in_i.mag[1];
      n2_vec_q <= n2_vec_d;
      n2_mx_q  <= mx;
      n3_vec_q <= n2_vec_q;
      n3_p_q   <= msb_pos(n2_mx_q);
      n4_ctl_q <= n3_vec_q.ctl;
      for (int i = 0; i < 3; i++) begin
        n4_a_q[i]  <= scale_mag(n3_vec_q.mag[i], n3_p_q);
        n5_sq_q[i] <= n4_a_q[i] * n4_a_q[i];
      end
      n5_ctl_q    <= n4_ctl_q;
      n5_a_q      <= n4_a_q;
      sq_ctl_q[0] <= n5_ctl_q;
      sq_a_q[0]   <= n5_a_q;
      sq_n_q[0]   <= MagW'(n5_sq_q[0]) + MagW'(n5_sq_q[1]) + MagW'(n5_sq_q[2]);
      sq_r_q[0]   <= '0;
    end
  end

  // bitwise integer square root; the sum stays below 2^62
  for (genvar k = 0; k < SqSteps; k++) begin : g_sqrt
    localparam logic [MagW-1:0] Bit = MagW'(1) << (2 * (SqSteps - 1 - k));
    logic [MagW:0]   trial;
    logic [MagW-1:0] n_d, r_d;
    always_comb begin
      trial = {1'b0, sq_r_q[k]} + {1'b0, Bit};
      if ({1'b0, sq_n_q[k]} >= trial) begin
        n_d = sq_n_q[k] - trial[MagW-1:0];
        r_d = (sq_r_q[k] >> 1) + Bit;
      end else begin
        n_d = sq_n_q[k];
        r_d = sq_r_q[k] >> 1;
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sq_ctl_q[k+1] <= sq_ctl_q[k];
        sq_a_q[k+1]   <= sq_a_q[k];
        sq_n_q[k+1]   <= n_d;
        sq_r_q[k+1]   <= r_d;
      end
    end
  end

  // dividend a*2^14 + len/2; len is at least 2^29
  assign len0 = sq_r_q[SqSteps][LenW-1:0];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dv_ctl_q[0] <= sq_ctl_q[SqSteps];
      dv_len_q[0] <= len0;
      for (int i = 0; i < 3; i++) begin
        dv_rem_q[0][i] <= RemW'({sq_a_q[SqSteps][i], 14'b0}) + RemW'(len0[LenW-1:1]);
        dv_quo_q[0][i] <= '0;
      end
    end
  end

  // restoring divider, quotient bit 14 first, three lanes
  for (genvar j = 0; j < DivSteps; j++) begin : g_div
    localparam int Sh = DivSteps - 1 - j;
    logic [RemW-1:0]      dsh;
    logic [2:0][RemW-1:0] rem_d;
    logic [2:0][QW-1:0]   quo_d;
    always_comb begin
      dsh = RemW'(dv_len_q[j]) << Sh;
      for (int i = 0; i < 3; i++) begin
        rem_d[i] = dv_rem_q[j][i];
        quo_d[i] = dv_quo_q[j][i];
        if (dv_rem_q[j][i] >= dsh) begin
          rem_d[i] = dv_rem_q[j][i] - dsh;
          quo_d[i] = dv_quo_q[j][i] | (QW'(1) << Sh);
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dv_ctl_q[j+1] <= dv_ctl_q[j];
        dv_len_q[j+1] <= dv_len_q[j];
        dv_rem_q[j+1] <= rem_d;
        dv_quo_q[j+1] <= quo_d;
      end
    end
  end

  always_comb begin
    oc = dv_ctl_q[DivSteps];
    for (int i = 0; i < 3; i++) begin
      comp[i] = oc.neg[i] ? 16'(-{1'b0, dv_quo_q[DivSteps][i]})
                          : {1'b0, dv_quo_q[DivSteps][i]};
    end
    if (oc.fixed) begin
      out_o = '{nx: oc.fx, ny: oc.fy, nz: oc.fz, status: oc.status};
    end else begin
      out_o = '{nx: comp[0], ny: comp[1], nz: comp[2], status: ST_OK};
    end
  end

  assign out_valid_o = v_q[NStages-1];

endmodule

[hdl/primitive_surface_normal.sv]
`timescale 1ns / 1ps
// primitive_surface_normal: top level, unit surface normal for scene primitives.
// Depends on psn_pkg, psn_front and psn_norm.
//
//  Channel   Dir  Handshake               Payload
//  s_axis    in   tvalid / tready         tuser: object_kind; tdata: box and hit point
//  m_axis    out  tvalid / tready         tuser: status; tdata: normal x, y, z
//  cfg       in   cfg_we_i                cfg_wdata_i: ramp_margin
//
// Pipeline: one item per cycle sustained while the output is not stalled; from acceptance
//   to m_axis_tvalid an item passes 9 geometry stages, 6 scaling and sum-of-squares
//   stages, a 31-stage square root, a dividend register, a 15-stage divider and the
//   output register.
// The square root and the divider, one result bit per stage, set the depth.
// Reset clears every valid bit and loads ramp_margin with 6554.
// A stalled output keeps its item in the output register; one more item lands
//   in a skid register, and only then does the whole pipeline hold.
module primitive_surface_normal (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata from bit 0: box_x_lo, box_x_hi, box_y_lo, box_y_hi, box_z_lo,
  // box_z_hi, hit_x, hit_y, hit_z (32 bits each)
  input  logic [287:0] s_axis_tdata,
  input  logic [2:0]   s_axis_tuser,   // object_kind
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [47:0]  m_axis_tdata,   // normal_x, normal_y, normal_z (16 bits each)
  output logic [1:0]   m_axis_tuser,   // status
  input  logic         cfg_we_i,
  input  logic [15:0]  cfg_wdata_i     // ramp_margin
);
  import psn_pkg::*;

  logic     en;
  logic     in_acc;
  psn_in_t  in_item;
  logic     mid_valid;
  psn_vec_t mid_vec;
  logic     res_valid;
  psn_res_t res;

  logic [15:0] ramp_margin_q;
  logic        out_v_q, skid_v_q;
  psn_res_t    out_q, skid_q;

  // pipeline moves whenever the skid register is free
  assign en            = !skid_v_q;
  assign s_axis_tready = en;
  assign in_acc        = s_axis_tvalid && en;

  assign in_item.kind = s_axis_tuser;
  assign in_item.xl   = s_axis_tdata[31:0];
  assign in_item.xh   = s_axis_tdata[63:32];
  assign in_item.yl   = s_axis_tdata[95:64];
  assign in_item.yh   = s_axis_tdata[127:96];
  assign in_item.zl   = s_axis_tdata[159:128];
  assign in_item.zh   = s_axis_tdata[191:160];
  assign in_item.hx   = s_axis_tdata[223:192];
  assign in_item.hy   = s_axis_tdata[255:224];
  assign in_item.hz   = s_axis_tdata[287:256];

  // written by user only while idle (not enforced), so every stage may read it directly
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ramp_margin_q <= RAMP_MARGIN_RST;
    end else if (cfg_we_i) begin
      ramp_margin_q <= cfg_wdata_i;
    end
  end

  psn_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .in_valid_i  (in_acc),
    .in_i        (in_item),
    .margin_i    (ramp_margin_q),
    .out_valid_o (mid_valid),
    .out_o       (mid_vec)
  );

  psn_norm u_norm (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .in_valid_i  (mid_valid),
    .in_i        (mid_vec),
    .out_valid_o (res_valid),
    .out_o       (res)
  );

  // output register with skid: res is consumed at every edge where en is high
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (!out_v_q || m_axis_tready) begin
      if (skid_v_q) begin
        out_v_q  <= 1'b1;
        skid_v_q <= 1'b0;
      end else begin
        out_v_q <= res_valid;
      end
    end else if (en && res_valid) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_v_q || m_axis_tready) begin
      out_q <= skid_v_q ? skid_q : res;
    end else if (en) begin
      skid_q <= res;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {out_q.nz, out_q.ny, out_q.nx};
  assign m_axis_tuser  = out_q.status;

endmodule

[sim/psn_checker.sv]
`timescale 1ns / 1ps
// psn_checker: watches both streams of primitive_surface_normal, computes the
// expected unit normal per accepted item and compares. Depends on psn_pkg.
module psn_checker (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [287:0] s_axis_tdata,
  input  logic [2:0]   s_axis_tuser,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [47:0]  m_axis_tdata,
  input  logic [1:0]   m_axis_tuser,
  input  logic         cfg_we_i,
  input  logic [15:0]  cfg_wdata_i,
  output int           fail_count,
  output int           pending,
  output int           normals_seen
);
  import psn_pkg::*;

  psn_res_t normal_q[$];
  logic [15:0] margin;

  function automatic longint sx(input logic [31:0] v);
    return longint'(signed'(v));
  endfunction

  function automatic longint unsigned absl(input longint v);
    return v < 0 ? longint'(-v) : v;
  endfunction

  function automatic int exp_for(input longint unsigned m);
    int e;
    e = 0;
    if (m == 0) return 0;
    while ((m >> e) >= (64'd1 << 30)) e++;
    if (e == 0) while ((m << (-e)) < (64'd1 << 29)) e--;
    return e;
  endfunction

  function automatic longint unsigned shift_by(input longint unsigned m, input int e);
    if (e >= 64) return 0;
    if (e >= 0) return m >> e;
    return m << (-e);
  endfunction

  function automatic psn_res_t unit_vec(input logic [2:0] neg,
                                        input longint unsigned m0, m1, m2);
    psn_res_t r;
    longint unsigned mx, len, sum, q, rr, b, n;
    longint unsigned a[3];
    int e;
    mx = m0;
    if (m1 > mx) mx = m1;
    if (m2 > mx) mx = m2;
    r = '{16'd0, 16'd0, 16'd0, ST_ZERO_LEN};
    if (mx == 0) return r;
    e = exp_for(mx);
    a[0] = shift_by(m0, e); a[1] = shift_by(m1, e); a[2] = shift_by(m2, e);
    sum = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
    // integer square root, bit by bit
    n = sum; rr = 0; b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= rr + b) begin n -= rr + b; rr = (rr >> 1) + b; end
      else rr >>= 1;
      b >>= 2;
    end
    len = rr;
    for (int i = 0; i < 3; i++) begin
      q = (a[i] * 16384 + len / 2) / len;
      a[i] = neg[i] ? -q : q;
    end
    r = '{a[0][15:0], a[1][15:0], a[2][15:0], ST_OK};
    return r;
  endfunction

  function automatic psn_res_t unit_signed(input longint x, y, z);
    return unit_vec({z < 0, y < 0, x < 0}, absl(x), absl(y), absl(z));
  endfunction

  function automatic psn_res_t predict_normal(input logic [2:0] kind,
                                              input logic [287:0] d);
    longint xl, xh, yl, yh, zl, zh, hx, hy, hz;
    longint dd, prod, off, blo, bhi, ux, uy, uz, dsum, h4;
    longint unsigned mx, my, mz, hm, ax, ay, bz, px, py, hh;
    int e1, e2, df;
    psn_res_t up;
    xl = sx(d[31:0]);    xh = sx(d[63:32]);
    yl = sx(d[95:64]);   yh = sx(d[127:96]);
    zl = sx(d[159:128]); zh = sx(d[191:160]);
    hx = sx(d[223:192]); hy = sx(d[255:224]); hz = sx(d[287:256]);
    up = '{16'd0, 16'd0, ONE_Q14, ST_OK};
    case (kind)
      KIND_FLAT, KIND_DISK: return up;
      KIND_RAMP: begin
        dd = xh - xl;
        prod = longint'({48'd0, margin}) * dd;
        if (prod >= 0) off = prod >>> 17;
        else off = -((-prod + 131071) >>> 17);
        blo = xl + off;
        bhi = xh - off;
        if (hx <= blo || hx >= bhi) return up;
        return unit_signed(-(zh - zl), 0, bhi - blo);
      end
      KIND_BALL: return unit_signed(2 * hx - (xl + xh), 2 * hy - (yl + yh),
                                    2 * hz - (zl + zh));
      KIND_CONE: begin
        ux = 2 * hx - (xl + xh); uy = 2 * hy - (yl + yh); uz = 2 * (hz - zh);
        mx = absl(ux); my = absl(uy); mz = absl(uz);
        if ((mx == 0 && my == 0) || mz == 0) return up;
        hm = mx > my ? mx : my;
        e1 = exp_for(hm); e2 = exp_for(mz);
        ax = shift_by(mx, e1); ay = shift_by(my, e1); bz = shift_by(mz, e2);
        px = bz * ax; py = bz * ay; hh = ax * ax + ay * ay;
        df = e2 - e1;
        if (df >= 0) hh = shift_by(hh, df);
        else begin px = shift_by(px, -df); py = shift_by(py, -df); end
        return unit_vec({1'b0, (uz < 0) == (uy < 0), (uz < 0) == (ux < 0)}, px, py, hh);
      end
      KIND_PYRAMID: begin
        dsum = (xh - xl) + (yh - yl);
        ux = 2 * hx - (xl + xh); uy = 2 * hy - (yl + yh);
        h4 = 4 * (zh - zl);
        mx = absl(ux); my = absl(uy);
        if (hz < zl || hz > zh || dsum < 0 || 2 * mx > dsum || 2 * my > dsum)
          return '{16'd0, 16'd0, 16'd0, ST_PYR_RANGE};
        if (hz <= zl) return '{16'd0, 16'd0, MINUS_ONE_Q14, ST_OK};
        if (mx > my) return unit_signed(ux < 0 ? -h4 : h4, 0, dsum);
        return unit_signed(0, uy < 0 ? -h4 : h4, dsum);
      end
      default: return '{16'd0, 16'd0, 16'd0, ST_BAD_KIND};
    endcase
  endfunction

  assign pending = normal_q.size();

  always_ff @(posedge clk_i or negedge rst_ni) begin
    psn_res_t want, got;
    if (!rst_ni) begin
      margin <= RAMP_MARGIN_RST;
      fail_count <= 0;
      normals_seen <= 0;
      normal_q.delete();
    end else begin
      if (cfg_we_i) margin <= cfg_wdata_i;
      if (s_axis_tvalid && s_axis_tready)
        normal_q.push_back(predict_normal(s_axis_tuser, s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        got = '{m_axis_tdata[15:0], m_axis_tdata[31:16], m_axis_tdata[47:32],
                m_axis_tuser};
        normals_seen <= normals_seen + 1;
        if (normal_q.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10) $display("unexpected normal %p", got);
        end else begin
          want = normal_q.pop_front();
          if (want != got) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10) $display("mismatch: expected %p got %p", want, got);
          end
        end
      end
    end
  end

endmodule

[sim/tb_primitive_surface_normal.sv]
`timescale 1ns / 1ps
// tb_primitive_surface_normal: stimulus and verdict for the surface normal unit.
// Depends on psn_pkg, psn_checker and the RTL under hdl.
module tb_primitive_surface_normal;
  import psn_pkg::*;

  localparam int LATENCY = 63;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [287:0] s_axis_tdata = '0;
  logic [2:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [47:0]  m_axis_tdata;
  logic [1:0]   m_axis_tuser;
  logic         cfg_we_i = 1'b0;
  logic [15:0]  cfg_wdata_i = '0;

  int fail_count, pending, normals_seen;
  int send_idle_pct = 0, recv_idle_pct = 0;
  logic hold_req = 1'b0;        // asks the receiver for one long hold-off
  logic hold_done = 1'b0;
  int hold_cycles = 0;          // receiver hold-off, counted down by its own process
  int items_sent = 0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  initial begin
    #50ms;
    $display("tb_primitive_surface_normal: errors");
    $finish;
  end

  primitive_surface_normal DUT (.*);

  psn_checker u_checker (.*);

  // receiver: random stalls, or a long hold-off when one is requested
  always @(posedge clk_i) begin
    if (hold_req && !hold_done) begin
      hold_done <= 1'b1;
      hold_cycles <= 199;
      m_axis_tready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // a mix of coordinates: extremes, small values and anything at all
  function automatic logic [31:0] rand_coord();
    case ($urandom_range(9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2, 3: return 32'($urandom_range(2 * 65536 * 8)) - 32'(65536 * 8);
      default: return $urandom();
    endcase
  endfunction

  // pack one item; most random ones have a hit inside the box
  function automatic logic [287:0] rand_item(input bit well_formed);
    logic [31:0] c[9];
    logic signed [31:0] lo, hi;
    for (int i = 0; i < 9; i++) c[i] = rand_coord();
    if (well_formed) begin
      for (int a = 0; a < 3; a++) begin
        lo = 32'($urandom_range(200000)) - 32'sd100000;
        hi = lo + 32'($urandom_range(300000));
        c[2 * a] = lo;
        c[2 * a + 1] = hi;
        case ($urandom_range(5))
          0: c[6 + a] = lo;
          1: c[6 + a] = hi;
          2: c[6 + a] = (lo + hi) >>> 1;
          default: c[6 + a] = lo + 32'($urandom_range(hi - lo));
        endcase
      end
    end
    return {c[8], c[7], c[6], c[5], c[4], c[3], c[2], c[1], c[0]};
  endfunction

  task automatic send(input logic [2:0] kind, input logic [287:0] data);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= kind;
    s_axis_tdata <= data;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic drain_and_write(input logic [15:0] margin);
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= margin;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic random_phase(input int count);
    logic [2:0] kind;
    for (int i = 0; i < count; i++) begin
      kind = ($urandom_range(19) == 0) ? 3'($urandom_range(7, 6)) : 3'($urandom_range(5));
      send(kind, rand_item($urandom_range(9) < 8));
    end
  endtask

  initial begin
    logic [287:0] d;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: every kind on a unit cube, a centre-top hit and an off-axis hit at the base
    for (int k = 0; k < 8; k++) begin
      // hit at the centre top: ball gives +Z, cone on the axis, pyramid apex
      send(3'(k), {32'sd65536, 32'sd0, 32'sd0, 32'sd65536, -32'sd65536,
                   32'sd65536, -32'sd65536, 32'sd65536, -32'sd65536});
      // hit off axis at the base
      send(3'(k), {-32'sd65536, 32'sd30000, 32'sd20000, 32'sd65536, -32'sd65536,
                   32'sd65536, -32'sd65536, 32'sd65536, -32'sd65536});
    end
    // ball hit at the box centre: zero-length normal
    send(KIND_BALL, {32'sd0, 32'sd0, 32'sd0, 32'sd65536, -32'sd65536, 32'sd65536,
                     -32'sd65536, 32'sd65536, -32'sd65536});
    // pyramid hit out of range, and inverted box
    send(KIND_PYRAMID, {32'sd0, 32'sd0, 32'sd900000, 32'sd65536, -32'sd65536,
                        32'sd65536, -32'sd65536, 32'sd65536, -32'sd65536});
    send(KIND_PYRAMID, {32'sd0, 32'sd0, 32'sd0, -32'sd65536, 32'sd65536,
                        -32'sd65536, 32'sd65536, -32'sd65536, 32'sd65536});
    // extreme coordinates: all minimum, all maximum, and two mixes of both
    d = {9{32'h8000_0000}};
    send(KIND_BALL, d);
    d = {9{32'h7FFF_FFFF}};
    send(KIND_CONE, d);
    d = {{4{32'h8000_0000}}, {5{32'h7FFF_FFFF}}};
    send(KIND_RAMP, d);
    send(KIND_BALL, ~d);

    // sender idles lightly, receiver heavily; long hold-off fills the pipeline
    send_idle_pct = 9; recv_idle_pct = 77;
    hold_req <= 1'b1;
    random_phase(350);

    drain_and_write(16'd0);
    random_phase(150);
    drain_and_write(16'hFFFF);
    send_idle_pct = 77; recv_idle_pct = 9;
    random_phase(300);
    drain_and_write(16'd32768);
    send_idle_pct = 0; recv_idle_pct = 0;
    random_phase(300);
    drain_and_write(16'($urandom()));
    random_phase(200);

    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
    $display("Sent %0d items over five ramp margins and three stall mixes,", items_sent);
    $display("%0d normals compared.", normals_seen);
    if (fail_count == 0) $display("tb_primitive_surface_normal: clean");
    else $display("tb_primitive_surface_normal: errors");
    $finish;
  end

endmodule
